@@ hw/rtl/mcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfp_pkg
// Shared types, codes and frame layout of the motor command frame parser.
// ----------------------------------------------------------------------------
package mcfp_pkg;

  // Burst length that is decoded
  localparam int FRAME_BYTES = 12;
  // Number of bytes stored from the start of a burst
  localparam int STORE_DEPTH = 12;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_LENGTH  = 2'd0;
  localparam logic [1:0] ST_HEADER  = 2'd1;
  localparam logic [1:0] ST_TRAILER = 2'd2;
  localparam logic [1:0] ST_APPLIED = 2'd3;

  // Value groups
  localparam logic [2:0] GRP_CHANGE = 3'd0;
  localparam logic [2:0] GRP_ANGLE  = 3'd1;
  localparam logic [2:0] GRP_SPEED  = 3'd2;
  localparam logic [2:0] GRP_TORQUE = 3'd3;
  localparam logic [2:0] GRP_NONE   = 3'd4;

  // Modes
  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_2 = 3'd2;
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_4 = 3'd4;

  // Header bytes
  localparam logic [7:0] HDR_CHANGE = 8'h00;
  localparam logic [7:0] HDR_ANGLE  = 8'h01;
  localparam logic [7:0] HDR_SPEED  = 8'h02;
  localparam logic [7:0] HDR_TORQUE = 8'h03;
  localparam logic [7:0] HDR_MODE_A = 8'h04;
  localparam logic [7:0] HDR_MODE_B = 8'h05;
  localparam logic [7:0] HDR_PIN    = 8'hFF;

  localparam logic [7:0] TRAILER    = 8'h0A;
  localparam int         HDR_IDX    = 0;
  localparam int         TRAIL_IDX  = 11;

  // Pin frame layout: level byte, flag byte and flag mask for each pin
  localparam int         NUM_PINS = 4;
  localparam logic [7:0] PIN_LOW  = 8'h00;
  localparam logic [7:0] PIN_HIGH = 8'h01;
  localparam int         PIN_LEVEL_IDX [NUM_PINS] = '{2, 4, 6, 8};
  localparam int         PIN_FLAG_IDX  [NUM_PINS] = '{10, 10, 9, 9};
  localparam logic [7:0] PIN_FLAG_MASK [NUM_PINS] = '{8'h01, 8'h10, 8'h01, 8'h10};

  typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

  typedef struct packed {
    logic byte_wr;    // store and count one byte
    logic burst_end;  // idle event: decode and restart the count
  } burst_ctl_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         group;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic [2:0]         mode;
    logic [NUM_PINS-1:0] pin_levels;
  } result_t;

endpackage

@@ hw/rtl/mcfp_in_if.sv @@
// ----------------------------------------------------------------------------
// mcfp_in_if
// Input channel: received bytes and line-idle events.
// ----------------------------------------------------------------------------
interface mcfp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

@@ hw/rtl/mcfp_out_if.sv @@
// ----------------------------------------------------------------------------
// mcfp_out_if
// Result channel: one decode result per line-idle event.
// ----------------------------------------------------------------------------
interface mcfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         group;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;
  logic signed [15:0] value_c;
  logic signed [15:0] value_d;
  logic [2:0]         mode;
  logic [3:0]         pin_levels;

  modport source (output valid, output status, output group, output value_a,
                  output value_b, output value_c, output value_d, output mode,
                  output pin_levels, input ready);
  modport sink   (input valid, input status, input group, input value_a,
                  input value_b, input value_c, input value_d, input mode,
                  input pin_levels, output ready);
endinterface

@@ hw/rtl/mcfp_burst.sv @@
// ----------------------------------------------------------------------------
// mcfp_burst
// Burst collector: stores the first bytes of a burst and counts its length.
// ----------------------------------------------------------------------------
module mcfp_burst (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcfp_pkg::burst_ctl_t          ctl,
  input  logic [7:0]                    wr_data,
  output mcfp_pkg::frame_t              frame,
  output logic [mcfp_pkg::COUNT_W-1:0]  count
);
  import mcfp_pkg::*;

  frame_t             frame_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.burst_end) begin
      count_r <= '0;
    end else if (ctl.byte_wr && (count_r != COUNT_MAX)) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  // Bytes past the stored window are counted but dropped
  always_ff @(posedge clk) begin
    if (ctl.byte_wr && (count_r < COUNT_W'(STORE_DEPTH))) begin
      frame_r[count_r[IDX_W-1:0]] <= wr_data;
    end
  end

  assign frame = frame_r;
  assign count = count_r;

endmodule

@@ hw/rtl/mcfp_decode.sv @@
// ----------------------------------------------------------------------------
// mcfp_decode
// Frame decoder: checks length and header, checks the trailer of value and
// pin frames, extracts values and keeps the mode and pin state.
// ----------------------------------------------------------------------------
module mcfp_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          apply,
  input  mcfp_pkg::frame_t              frame,
  input  logic [mcfp_pkg::COUNT_W-1:0]  count,
  output mcfp_pkg::result_t             result
);
  import mcfp_pkg::*;

  logic [2:0]          mode_r;
  logic [2:0]          mode_nxt;
  logic [NUM_PINS-1:0] pins_r;
  logic [NUM_PINS-1:0] pins_nxt;
  logic [7:0]          hdr;
  logic                trailer_ok;
  logic                flag_set;
  logic [7:0]          level;

  always_comb begin
    hdr        = frame[HDR_IDX];
    trailer_ok = (frame[TRAIL_IDX] == TRAILER);
    mode_nxt   = mode_r;
    pins_nxt   = pins_r;
    flag_set   = 1'b0;
    level      = '0;
    result     = '0;
    result.status = ST_LENGTH;
    result.group  = GRP_NONE;

    if (count == COUNT_W'(FRAME_BYTES)) begin
      unique case (hdr) inside
        HDR_CHANGE, HDR_ANGLE, HDR_SPEED, HDR_TORQUE: begin
          if (trailer_ok) begin
            result.status  = ST_APPLIED;
            result.group   = hdr[2:0];
            result.value_a = $signed({frame[1], frame[2]});
            result.value_b = $signed({frame[3], frame[4]});
            result.value_c = $signed({frame[5], frame[6]});
            result.value_d = $signed({frame[7], frame[8]});
            case (hdr)
              HDR_CHANGE: mode_nxt = MODE_0;
              HDR_ANGLE:  mode_nxt = MODE_1;
              HDR_TORQUE: mode_nxt = MODE_2;
              default:    mode_nxt = mode_r;   // speed frame keeps the mode
            endcase
          end else begin
            result.status = ST_TRAILER;
          end
        end
        HDR_MODE_A: begin
          result.status = ST_APPLIED;
          mode_nxt      = MODE_3;
        end
        HDR_MODE_B: begin
          result.status = ST_APPLIED;
          mode_nxt      = MODE_4;
        end
        HDR_PIN: begin
          if (trailer_ok) begin
            result.status = ST_APPLIED;
            // clear on level 0 with flag clear, set on level 1 with flag set
            for (int i = 0; i < NUM_PINS; i++) begin
              level    = frame[PIN_LEVEL_IDX[i]];
              flag_set = |(frame[PIN_FLAG_IDX[i]] & PIN_FLAG_MASK[i]);
              if ((level == PIN_LOW) && !flag_set) begin
                pins_nxt[i] = 1'b0;
              end else if ((level == PIN_HIGH) && flag_set) begin
                pins_nxt[i] = 1'b1;
              end
            end
          end else begin
            result.status = ST_TRAILER;
          end
        end
        default: result.status = ST_HEADER;
      endcase
    end

    result.mode       = mode_nxt;
    result.pin_levels = pins_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_0;
      pins_r <= '0;
    end else if (apply) begin
      mode_r <= mode_nxt;
      pins_r <= pins_nxt;
    end
  end

endmodule

@@ hw/rtl/motor_command_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// motor_command_frame_parser_unit
// Collects received bytes into bursts and decodes a motor command frame on
// each line-idle event.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per received byte (op = 0) or per line-idle event
//   (op = 1). Byte items produce no result; every idle item produces exactly
//   one result on out_ch: status, value group, four signed values, and the
//   mode and pin levels as they stand after the frame.
//   Path: an accepted idle item is held in the input register and is then
//   loaded into the result register, from which out_ch can take it (the
//   decoder between the input register and the result register is
//   combinational).
//   Throughput: one item per cycle, sustained while no result is held off;
//   the input register and the result register each hold one item.
//   Stall: while out_ch is held off, the result register keeps its item, the
//   input register can still take one more item (bytes keep flowing through
//   it), and in_ch.ready drops only once an idle item waits behind a held
//   result.
//   Reset (rst_n low, synchronous) empties both registers, clears the byte
//   count, the mode and the pin levels. Stored frame bytes are not cleared.
// ----------------------------------------------------------------------------
module motor_command_frame_parser_unit (
  input  logic          clk,
  input  logic          rst_n,
  mcfp_in_if.sink       in_ch,
  mcfp_out_if.source    out_ch
);
  import mcfp_pkg::*;

  logic               s1_valid_r;
  logic               s1_op_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  result_t            out_item_r;
  logic               out_free;
  logic               s1_adv;
  logic               in_take;
  burst_ctl_t         burst_ctl;
  frame_t             frame;
  logic [COUNT_W-1:0] count;
  result_t            result;

  assign out_free = !out_valid_r || out_ch.ready;
  // A byte never waits on the result side
  assign s1_adv   = s1_valid_r && ((s1_op_r == OP_BYTE) || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_ch.op;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  assign burst_ctl.byte_wr   = s1_adv && (s1_op_r == OP_BYTE);
  assign burst_ctl.burst_end = s1_adv && (s1_op_r == OP_IDLE);

  mcfp_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (burst_ctl),
    .wr_data (s1_byte_r),
    .frame   (frame),
    .count   (count)
  );

  mcfp_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .apply  (burst_ctl.burst_end),
    .frame  (frame),
    .count  (count),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (burst_ctl.burst_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_ctl.burst_end) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_item_r.status;
  assign out_ch.group      = out_item_r.group;
  assign out_ch.value_a    = out_item_r.value_a;
  assign out_ch.value_b    = out_item_r.value_b;
  assign out_ch.value_c    = out_item_r.value_c;
  assign out_ch.value_d    = out_item_r.value_d;
  assign out_ch.mode       = out_item_r.mode;
  assign out_ch.pin_levels = out_item_r.pin_levels;

endmodule

@@ hw/rtl/mcfp_checker.sv @@
// ----------------------------------------------------------------------------
// mcfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module mcfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [2:0]         out_group,
  input logic signed [15:0] out_value_a,
  input logic signed [15:0] out_value_b,
  input logic signed [15:0] out_value_c,
  input logic signed [15:0] out_value_d,
  input logic [2:0]         out_mode,
  input logic [3:0]         out_pin_levels
);
  import mcfp_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_group) &&
      $stable(out_value_a) && $stable(out_value_b) && $stable(out_value_c) &&
      $stable(out_value_d) && $stable(out_mode) && $stable(out_pin_levels))
    else $error("result changed while held");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result that starts from an empty register comes from an idle item
  // that was accepted on in_ch and passed through the input register
  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_op == OP_IDLE), 2))
    else $error("result without an idle item");

  // Values are only carried by an applied frame, and zero otherwise
  a_group_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_APPLIED) |->
      (out_group == GRP_NONE) && (out_value_a == 16'sd0) &&
      (out_value_b == 16'sd0) && (out_value_c == 16'sd0) &&
      (out_value_d == 16'sd0))
    else $error("values carried by a rejected frame");

endmodule

bind motor_command_frame_parser_unit mcfp_checker u_mcfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_group      (out_ch.group),
  .out_value_a    (out_ch.value_a),
  .out_value_b    (out_ch.value_b),
  .out_value_c    (out_ch.value_c),
  .out_value_d    (out_ch.value_d),
  .out_mode       (out_ch.mode),
  .out_pin_levels (out_ch.pin_levels)
);
